### rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, defaults and types of the matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int DATA_W       = 32;  // matrix entries and quaternion components
  localparam int FRAC_BITS_DEF = 30;  // default fraction bits
  localparam int WIDE_W       = 36;  // selected vector terms before scaling
  localparam int RAW_MAG_W    = 35;  // magnitude of a selected term
  localparam int MAG_W        = 31;  // magnitude after block scaling
  localparam int N2_W         = 64;  // sum of squares
  localparam int NORM_W       = 32;  // integer root of the sum of squares

  // branch codes
  localparam logic [1:0] BR_R00   = 2'd0;
  localparam logic [1:0] BR_R11   = 2'd1;
  localparam logic [1:0] BR_R22   = 2'd2;
  localparam logic [1:0] BR_TRACE = 2'd3;

  typedef logic [3:0][MAG_W-1:0] rmq_mags_t;

  // sideband that travels with each request
  typedef struct packed {
    logic [1:0] br;
    logic       bad;
    logic [3:0] neg;
  } rmq_side_t;

endpackage

### rtl/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Branch choice, vector terms, block scaling, squares and their sum.
// Five register stages.
// ----------------------------------------------------------------------------
module rmq_front #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [rmq_pkg::DATA_W-1:0]   r00_i,
  input  logic signed [rmq_pkg::DATA_W-1:0]   r01_i,
  input  logic signed [rmq_pkg::DATA_W-1:0]   r02_i,
  input  logic signed [rmq_pkg::DATA_W-1:0]   r10_i,
  input  logic signed [rmq_pkg::DATA_W-1:0]   r11_i,
  input  logic signed [rmq_pkg::DATA_W-1:0]   r12_i,
  input  logic signed [rmq_pkg::DATA_W-1:0]   r20_i,
  input  logic signed [rmq_pkg::DATA_W-1:0]   r21_i,
  input  logic signed [rmq_pkg::DATA_W-1:0]   r22_i,
  output logic                                valid_o,
  output logic [rmq_pkg::N2_W-1:0]            n2_o,
  output rmq_pkg::rmq_mags_t                  mags_o,
  output rmq_pkg::rmq_side_t                  side_o
);
  import rmq_pkg::*;

  localparam logic signed [WIDE_W-1:0] ONE = WIDE_W'(1) <<< FRAC_BITS;

  logic [4:0] vld_q;

  // stage 1: trace, sums and differences
  logic signed [DATA_W-1:0] dg0_q, dg1_q, dg2_q;
  logic signed [DATA_W+1:0] tr_q;
  logic signed [DATA_W:0]   s01_q, s02_q, s12_q, d12_q, d20_q, d01_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dg0_q <= r00_i;
      dg1_q <= r11_i;
      dg2_q <= r22_i;
      tr_q  <= (DATA_W+2)'(r00_i) + (DATA_W+2)'(r11_i) + (DATA_W+2)'(r22_i);
      s01_q <= (DATA_W+1)'(r01_i) + (DATA_W+1)'(r10_i);
      s02_q <= (DATA_W+1)'(r02_i) + (DATA_W+1)'(r20_i);
      s12_q <= (DATA_W+1)'(r12_i) + (DATA_W+1)'(r21_i);
      d12_q <= (DATA_W+1)'(r12_i) - (DATA_W+1)'(r21_i);
      d20_q <= (DATA_W+1)'(r20_i) - (DATA_W+1)'(r02_i);
      d01_q <= (DATA_W+1)'(r01_i) - (DATA_W+1)'(r10_i);
    end
  end

  // stage 2: branch, argument, vector terms, magnitudes and signs
  logic [1:0]               br_d;
  logic signed [DATA_W+1:0] best;
  logic signed [DATA_W-1:0] dsel;
  logic signed [WIDE_W-1:0] arg;
  logic signed [WIDE_W-1:0] vt [4];
  logic [3:0][RAW_MAG_W-1:0] rmag_d;
  logic [3:0]               neg_d;
  logic [3:0][RAW_MAG_W-1:0] rmag_q;
  rmq_side_t                side2_q;

  always_comb begin
    br_d = BR_R00;
    best = (DATA_W+2)'(dg0_q);
    if ((DATA_W+2)'(dg1_q) > best) begin
      br_d = BR_R11;
      best = (DATA_W+2)'(dg1_q);
    end
    if ((DATA_W+2)'(dg2_q) > best) begin
      br_d = BR_R22;
      best = (DATA_W+2)'(dg2_q);
    end
    if (tr_q > best) begin
      br_d = BR_TRACE;
    end
    unique case (br_d)
      BR_R00:  dsel = dg0_q;
      BR_R11:  dsel = dg1_q;
      default: dsel = dg2_q;
    endcase
    if (br_d == BR_TRACE) begin
      arg = ONE + WIDE_W'(tr_q);
    end else begin
      arg = ONE + (WIDE_W'(dsel) <<< 1) - WIDE_W'(tr_q);
    end
    unique case (br_d)
      BR_R00: begin
        vt[0] = arg;            vt[1] = WIDE_W'(s01_q);
        vt[2] = WIDE_W'(s02_q); vt[3] = WIDE_W'(d12_q);
      end
      BR_R11: begin
        vt[0] = WIDE_W'(s01_q); vt[1] = arg;
        vt[2] = WIDE_W'(s12_q); vt[3] = WIDE_W'(d20_q);
      end
      BR_R22: begin
        vt[0] = WIDE_W'(s02_q); vt[1] = WIDE_W'(s12_q);
        vt[2] = arg;            vt[3] = WIDE_W'(d01_q);
      end
      default: begin
        vt[0] = WIDE_W'(d12_q); vt[1] = WIDE_W'(d20_q);
        vt[2] = WIDE_W'(d01_q); vt[3] = arg;
      end
    endcase
    // flipping all signs when w is negative leaves magnitudes alone
    for (int i = 0; i < 4; i++) begin
      rmag_d[i] = vt[i][WIDE_W-1] ? RAW_MAG_W'(-vt[i]) : RAW_MAG_W'(vt[i]);
      neg_d[i]  = vt[i][WIDE_W-1] ^ vt[3][WIDE_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rmag_q      <= rmag_d;
      side2_q.br  <= br_d;
      side2_q.bad <= (arg <= WIDE_W'(0));
      side2_q.neg <= neg_d;
    end
  end

  // stage 3: common right shift so every magnitude fits 31 bits
  logic [RAW_MAG_W-1:0] any_mag;
  rmq_mags_t            smag_d, smag3_q, smag4_q, smag5_q;
  rmq_side_t            side3_q, side4_q, side5_q;

  always_comb begin
    any_mag = rmag_q[0] | rmag_q[1] | rmag_q[2] | rmag_q[3];
    for (int i = 0; i < 4; i++) begin
      priority if (any_mag[34]) smag_d[i] = MAG_W'(rmag_q[i] >> 4);
      else if (any_mag[33])     smag_d[i] = MAG_W'(rmag_q[i] >> 3);
      else if (any_mag[32])     smag_d[i] = MAG_W'(rmag_q[i] >> 2);
      else if (any_mag[31])     smag_d[i] = MAG_W'(rmag_q[i] >> 1);
      else                      smag_d[i] = MAG_W'(rmag_q[i]);
    end
  end

  // stage 4: squares, stage 5: their sum
  logic [3:0][2*MAG_W-1:0] sq_q;
  logic [N2_W-1:0]         n2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      smag3_q <= smag_d;
      side3_q <= side2_q;
      for (int i = 0; i < 4; i++) begin
        sq_q[i] <= (2*MAG_W)'(smag3_q[i]) * (2*MAG_W)'(smag3_q[i]);
      end
      smag4_q <= smag3_q;
      side4_q <= side3_q;
      n2_q    <= N2_W'(sq_q[0]) + N2_W'(sq_q[1]) + N2_W'(sq_q[2]) + N2_W'(sq_q[3]);
      smag5_q <= smag4_q;
      side5_q <= side4_q;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  assign valid_o = vld_q[4];
  assign n2_o    = n2_q;
  assign mags_o  = smag5_q;
  assign side_o  = side5_q;

endmodule

### rtl/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Integer square root of the sum of squares, one result bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [rmq_pkg::N2_W-1:0]   n2_i,
  input  rmq_pkg::rmq_mags_t         mags_i,
  input  rmq_pkg::rmq_side_t         side_i,
  output logic                       valid_o,
  output logic [rmq_pkg::NORM_W-1:0] norm_o,
  output rmq_pkg::rmq_mags_t         mags_o,
  output rmq_pkg::rmq_side_t         side_o
);
  import rmq_pkg::*;

  localparam int STEPS = N2_W / 2;

  logic [STEPS:0]  vld_q;
  logic [N2_W-1:0] rem_q  [STEPS+1];
  logic [N2_W-1:0] root_q [STEPS+1];
  rmq_mags_t       mags_q [STEPS+1];
  rmq_side_t       side_q [STEPS+1];

  assign vld_q[0]  = valid_i;
  assign rem_q[0]  = n2_i;
  assign root_q[0] = '0;
  assign mags_q[0] = mags_i;
  assign side_q[0] = side_i;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int SH = N2_W - 2 - 2*k;
    logic [N2_W-1:0] trial, rem_d, root_d;

    // one digit of the restoring root
    always_comb begin
      trial = root_q[k] + (N2_W'(1) << SH);
      if (rem_q[k] >= trial) begin
        rem_d  = rem_q[k] - trial;
        root_d = (root_q[k] >> 1) + (N2_W'(1) << SH);
      end else begin
        rem_d  = rem_q[k];
        root_d = root_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= rem_d;
        root_q[k+1] <= root_d;
        mags_q[k+1] <= mags_q[k];
        side_q[k+1] <= side_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  assign valid_o = vld_q[STEPS];
  assign norm_o  = root_q[STEPS][NORM_W-1:0];
  assign mags_o  = mags_q[STEPS];
  assign side_o  = side_q[STEPS];

endmodule

### rtl/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Rounded division of the four magnitudes by the norm, one quotient bit per
// stage for all four lanes, then sign and bad-input handling.
// ----------------------------------------------------------------------------
module rmq_div #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [rmq_pkg::NORM_W-1:0]        norm_i,
  input  rmq_pkg::rmq_mags_t                mags_i,
  input  rmq_pkg::rmq_side_t                side_i,
  output logic                              valid_o,
  output logic [3:0][rmq_pkg::DATA_W-1:0]   quat_o,
  output logic [1:0]                        br_o,
  output logic                              bad_o
);
  import rmq_pkg::*;

  localparam int STEPS = FRAC_BITS + 1;

  logic [STEPS:0]              vld_q;
  logic [3:0][N2_W-1:0]        num_q  [STEPS+1];
  logic [3:0][DATA_W-1:0]      quo_q  [STEPS+1];
  logic [NORM_W-1:0]           norm_q [STEPS+1];
  rmq_side_t                   side_q [STEPS+1];

  // prep stage: numerator with half the divisor added for rounding
  logic [NORM_W-1:0] norm_fix;
  assign norm_fix = (norm_i == '0) ? NORM_W'(1) : norm_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        num_q[0][i] <= (N2_W'(mags_i[i]) << FRAC_BITS) + N2_W'(norm_fix >> 1);
      end
      quo_q[0]  <= '0;
      norm_q[0] <= norm_fix;
      side_q[0] <= side_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int SH = FRAC_BITS - k;
    logic [N2_W-1:0]        dsh;
    logic [3:0][N2_W-1:0]   num_d;
    logic [3:0][DATA_W-1:0] quo_d;

    // compare against the shifted divisor in every lane
    always_comb begin
      dsh = N2_W'(norm_q[k]) << SH;
      for (int i = 0; i < 4; i++) begin
        if (num_q[k][i] >= dsh) begin
          num_d[i] = num_q[k][i] - dsh;
          quo_d[i] = {quo_q[k][i][DATA_W-2:0], 1'b1};
        end else begin
          num_d[i] = num_q[k][i];
          quo_d[i] = {quo_q[k][i][DATA_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k+1]  <= num_d;
        quo_q[k+1]  <= quo_d;
        norm_q[k+1] <= norm_q[k];
        side_q[k+1] <= side_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  // apply signs, clear on bad input
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (side_q[STEPS].bad) begin
        quat_o[i] = '0;
      end else if (side_q[STEPS].neg[i]) begin
        quat_o[i] = -quo_q[STEPS][i];
      end else begin
        quat_o[i] = quo_q[STEPS][i];
      end
    end
  end

  assign valid_o = vld_q[STEPS];
  assign br_o    = side_q[STEPS].br;
  assign bad_o   = side_q[STEPS].bad;

endmodule

### rtl/rotation_matrix_to_quaternion_unit.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Fixed-point rotation matrix to unit quaternion converter (Shepperd).
// ----------------------------------------------------------------------------
// Fully pipelined: a new matrix request is taken every clock cycle unless the
// output stalls. The pipeline is 5 front stages, 32 square-root stages (one
// root bit each), 1 divider prep stage plus FRAC_BITS+1 divider stages (one
// quotient bit each), and the output register. The divider and root stages
// set this depth. A stall on the output freezes the whole pipeline; nothing
// is dropped or repeated. Results come out in request order.
module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic signed [rmq_pkg::DATA_W-1:0] r00_i,
  input  logic signed [rmq_pkg::DATA_W-1:0] r01_i,
  input  logic signed [rmq_pkg::DATA_W-1:0] r02_i,
  input  logic signed [rmq_pkg::DATA_W-1:0] r10_i,
  input  logic signed [rmq_pkg::DATA_W-1:0] r11_i,
  input  logic signed [rmq_pkg::DATA_W-1:0] r12_i,
  input  logic signed [rmq_pkg::DATA_W-1:0] r20_i,
  input  logic signed [rmq_pkg::DATA_W-1:0] r21_i,
  input  logic signed [rmq_pkg::DATA_W-1:0] r22_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic signed [rmq_pkg::DATA_W-1:0] quat_x_o,
  output logic signed [rmq_pkg::DATA_W-1:0] quat_y_o,
  output logic signed [rmq_pkg::DATA_W-1:0] quat_z_o,
  output logic signed [rmq_pkg::DATA_W-1:0] quat_w_o,
  output logic [1:0]                        branch_taken_o,
  output logic                              bad_input_o
);
  import rmq_pkg::*;

  logic en;
  logic out_vld_q;

  // pipeline advances unless a held result is stalled
  assign en      = !(out_vld_q && stall_i);
  assign stall_o = !en;

  logic              f_vld;
  logic [N2_W-1:0]   f_n2;
  rmq_mags_t         f_mags;
  rmq_side_t         f_side;

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i,
    .r00_i, .r01_i, .r02_i, .r10_i, .r11_i, .r12_i, .r20_i, .r21_i, .r22_i,
    .valid_o(f_vld), .n2_o(f_n2), .mags_o(f_mags), .side_o(f_side)
  );

  logic              s_vld;
  logic [NORM_W-1:0] s_norm;
  rmq_mags_t         s_mags;
  rmq_side_t         s_side;

  rmq_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_vld), .n2_i(f_n2),
    .mags_i(f_mags), .side_i(f_side),
    .valid_o(s_vld), .norm_o(s_norm), .mags_o(s_mags), .side_o(s_side)
  );

  logic                   d_vld;
  logic [3:0][DATA_W-1:0] d_quat;
  logic [1:0]             d_br;
  logic                   d_bad;

  rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_vld), .norm_i(s_norm),
    .mags_i(s_mags), .side_i(s_side),
    .valid_o(d_vld), .quat_o(d_quat), .br_o(d_br), .bad_o(d_bad)
  );

  // output register
  logic [3:0][DATA_W-1:0] quat_q;
  logic [1:0]             br_q;
  logic                   bad_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      quat_q <= d_quat;
      br_q   <= d_br;
      bad_q  <= d_bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d_vld;
    end
  end

  assign valid_o        = out_vld_q;
  assign quat_x_o       = quat_q[0];
  assign quat_y_o       = quat_q[1];
  assign quat_z_o       = quat_q[2];
  assign quat_w_o       = quat_q[3];
  assign branch_taken_o = br_q;
  assign bad_input_o    = bad_q;

endmodule
